// ----- src/msw_pkg.sv -----
// ----------------------------------------------------------------------------
// msw_pkg
// Shared constants and types for the mid/side allpass stereo widener.
// ----------------------------------------------------------------------------
package msw_pkg;

    localparam int ACC_BITS = 32;

    localparam logic [ACC_BITS-1:0] SAT_HI = 32'h7FFF_FFFF;
    localparam logic [ACC_BITS-1:0] SAT_LO = 32'h8000_0000;

    localparam logic [1:0] CFG_COUNT  = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_OUTGN  = 2'd2;
    localparam logic [1:0] CFG_MONO   = 2'd3;

    // sequencer states, one-hot
    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MUL  = 7'b0000010,
        ST_EXEC = 7'b0000100,
        ST_NEXT = 7'b0001000,
        ST_POST = 7'b0010000,
        ST_OUT  = 7'b0100000,
        ST_PREP = 7'b1000000
    } state_t;

    // saturate a wide signed value to 32 bits
    function automatic logic signed [ACC_BITS-1:0] sat32(input logic signed [63:0] v);
        logic signed [ACC_BITS-1:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF)
            r = SAT_HI;
        else if (v < -64'sh0000_0000_8000_0000)
            r = SAT_LO;
        else
            r = v[ACC_BITS-1:0];
        return r;
    endfunction

endpackage

// ----- src/mid_side_allpass_stereo_widener_core.sv -----
// ----------------------------------------------------------------------------
// mid_side_allpass_stereo_widener_core
// Mid/side stereo widener: allpass cascade on mid, LR low/high split,
// width and output gain, mono option, 24-bit saturation.
// ----------------------------------------------------------------------------
// Usage:
//  s_axis beats carry either a coefficient load (operation = 1) or a sample
//  pair (operation = 0). A load with an index inside the table writes one
//  table slot in the accepting cycle, makes no output beat, and the next
//  beat can follow right away. A sample pair makes one m_axis beat with
//  the left and right results. All multiplies go through one shift-add
//  multiplier that takes one multiplier bit per cycle between a load step
//  (ST_NEXT) and a finish step (ST_EXEC). A pair with N active allpass
//  sections needs 2N + 8 coefficient products, the width product and two
//  gain products (one in mono mode). After the last product the result is
//  loaded into the output register in ST_OUT, which raises m_tvalid, and the
//  block passes through ST_POST back to ST_IDLE to take the next beat.
//  s_tready is high only while no pair is in work. The result moves into an
//  output register, so a stalled receiver does not hold off the next input;
//  only a second result waits for m_tready before the block goes on.
//  Reset clears delays and coefficients and loads the register defaults
//  (count 8, width 16384, gain 8192, stereo).
// ----------------------------------------------------------------------------
module mid_side_allpass_stereo_widener_core #(
    parameter int ALLPASS_STAGES = 16,
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_BITS      = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // left_sample, right_sample, coef_index(5), coef_value, zero fill
    input  logic [((2*SAMPLE_BITS+5+COEF_BITS+7)/8)*8-1:0] s_tdata,
    // operation
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // left_out, right_out
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_tdata,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_index,
    input  logic [15:0]                    cfg_data
);
    import msw_pkg::*;

    localparam int FRAC     = COEF_BITS - 3;
    localparam int DEPTH    = ALLPASS_STAGES + 6;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int SLOT_LP  = ALLPASS_STAGES;
    localparam int SLOT_HP  = ALLPASS_STAGES + 3;
    localparam int MP_W     = (COEF_BITS > 17) ? COEF_BITS : 17;
    localparam int MCNT_W   = $clog2(MP_W + 1);
    localparam int STEP_W   = 5;
    localparam int STG_W    = $clog2(ALLPASS_STAGES + 1);
    localparam int AP_W     = (ALLPASS_STAGES > 1) ? $clog2(ALLPASS_STAGES) : 1;
    localparam int IN_W     = ((2*SAMPLE_BITS+5+COEF_BITS+7)/8)*8;
    localparam int OUT_W    = ((2*SAMPLE_BITS+7)/8)*8;
    localparam int SL_W     = 36;
    localparam int MC_W     = 38;
    localparam int PROD_W   = MC_W + MP_W;

    // micro steps
    localparam logic [STEP_W-1:0] S_AP_Y   = 5'd0;
    localparam logic [STEP_W-1:0] S_AP_D   = 5'd1;
    localparam logic [STEP_W-1:0] S_LR_A0  = 5'd2;
    localparam logic [STEP_W-1:0] S_LR_A1  = 5'd3;
    localparam logic [STEP_W-1:0] S_LR_B1  = 5'd4;
    localparam logic [STEP_W-1:0] S_LR_B2  = 5'd5;
    localparam logic [STEP_W-1:0] S_WIDTH  = 5'd6;
    localparam logic [STEP_W-1:0] S_GL     = 5'd7;
    localparam logic [STEP_W-1:0] S_GR     = 5'd8;

    // ---------------- registers ----------------
    logic [4:0]  count_reg;
    logic [15:0] width_reg;
    logic [14:0] outgn_reg;
    logic        mono_reg;

    logic signed [COEF_BITS-1:0] coef_reg  [DEPTH];
    logic signed [31:0]          apd_reg   [ALLPASS_STAGES];
    logic signed [31:0]          lpd_reg   [2];
    logic signed [31:0]          hpd_reg   [2];

    state_t                      state_reg;
    logic [STEP_W-1:0]           step_reg;
    logic [AP_W-1:0]             stg_reg;
    logic                        hp_reg;   // 0 lowpass, 1 highpass section
    logic signed [31:0]          x_reg;    // current chain value
    logic signed [31:0]          y_reg;
    logic signed [39:0]          t_reg;    // a0*x product
    logic signed [39:0]          u_reg;    // a1*x product, sign applied
    logic signed [SAMPLE_BITS:0] mid_reg;
    logic signed [SAMPLE_BITS:0] side_reg;
    logic signed [SL_W-1:0]      sl_reg;
    logic signed [SL_W-1:0]      sr_reg;
    logic signed [SAMPLE_BITS-1:0] ol_reg;
    logic signed [SAMPLE_BITS-1:0] or_reg;
    logic [2*SAMPLE_BITS-1:0]    out_reg;
    logic                        mval_reg;

    // serial multiplier: multiplicand fixed, multiplier shifted one bit a cycle
    logic signed [PROD_W-1:0]    acc_reg;
    logic signed [MC_W-1:0]      mcand_reg;
    logic [MP_W-1:0]             mplier_reg;
    logic                        mfirst_reg;
    logic [MCNT_W-1:0]           mcnt_reg;
    logic [4:0]                  shift_reg;

    logic [STG_W-1:0] n_eff;
    assign n_eff = (32'(count_reg) > 32'(ALLPASS_STAGES)) ? STG_W'(ALLPASS_STAGES)
                                                          : STG_W'(count_reg);

    wire logic                   s_op   = s_tuser;
    wire logic [SAMPLE_BITS-1:0] s_l    = s_tdata[SAMPLE_BITS-1:0];
    wire logic [SAMPLE_BITS-1:0] s_r    = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    wire logic [4:0]             s_idx  = s_tdata[2*SAMPLE_BITS+4:2*SAMPLE_BITS];
    wire logic [COEF_BITS-1:0]   s_cv   = s_tdata[2*SAMPLE_BITS+5+COEF_BITS-1:2*SAMPLE_BITS+5];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mval_reg;
    assign m_tdata  = OUT_W'(out_reg);

    logic [IDX_W-1:0] base;
    assign base = hp_reg ? IDX_W'(SLOT_HP) : IDX_W'(SLOT_LP);

    // rounded product: floor((acc + half) >> sh), computed combinationally
    logic signed [PROD_W:0] rnd_sum;
    logic signed [63:0]     prod_r;
    always_comb
    begin
        rnd_sum = {acc_reg[PROD_W-1], acc_reg} + ((PROD_W+1)'(1) << (shift_reg - 5'd1));
        prod_r  = 64'(rnd_sum >>> shift_reg);
    end

    // multiplier operands for each step; multiplier is left aligned
    logic signed [MC_W-1:0] op_x;
    logic [MP_W-1:0]        op_c;
    logic [4:0]             op_sh;
    logic [MCNT_W-1:0]      op_n;
    logic [IDX_W-1:0]       stg_idx;
    assign stg_idx = IDX_W'(stg_reg);
    always_comb
    begin
        op_x  = MC_W'(x_reg);
        op_c  = MP_W'(coef_reg[stg_idx]) << (MP_W - COEF_BITS);
        op_sh = 5'(FRAC);
        op_n  = MCNT_W'(COEF_BITS);
        case (step_reg)
            S_AP_Y:  begin op_x = MC_W'(x_reg);
                           op_c = MP_W'(coef_reg[stg_idx]) << (MP_W - COEF_BITS); end
            S_AP_D:  begin op_x = MC_W'(y_reg);
                           op_c = MP_W'(coef_reg[stg_idx]) << (MP_W - COEF_BITS); end
            S_LR_A0: begin op_x = MC_W'(x_reg);
                           op_c = MP_W'(coef_reg[base]) << (MP_W - COEF_BITS); end
            S_LR_A1: begin op_x = MC_W'(x_reg);
                           op_c = MP_W'(coef_reg[base]) << (MP_W - COEF_BITS);
                           op_sh = 5'(FRAC-1); end
            S_LR_B1: begin op_x = MC_W'(y_reg);
                           op_c = MP_W'(coef_reg[base+IDX_W'(1)]) << (MP_W - COEF_BITS); end
            S_LR_B2: begin op_x = MC_W'(y_reg);
                           op_c = MP_W'(coef_reg[base+IDX_W'(2)]) << (MP_W - COEF_BITS); end
            // highpass output is negated before the width gain, unsaturated
            S_WIDTH: begin op_x = -MC_W'(y_reg);
                           op_c = MP_W'(width_reg) << (MP_W - 17);
                           op_sh = 5'd15; op_n = MCNT_W'(17); end
            S_GL:    begin op_x = mono_reg ? MC_W'(sl_reg) + MC_W'(sr_reg) : MC_W'(sl_reg);
                           op_c = MP_W'(outgn_reg) << (MP_W - 16);
                           op_sh = mono_reg ? 5'd15 : 5'd14; op_n = MCNT_W'(16); end
            S_GR:    begin op_x = MC_W'(sr_reg);
                           op_c = MP_W'(outgn_reg) << (MP_W - 16);
                           op_sh = 5'd14; op_n = MCNT_W'(16); end
            default: ;
        endcase
    end

    function automatic logic signed [SAMPLE_BITS-1:0] sat_out(input logic signed [63:0] v);
        logic signed [63:0] hi;
        hi = (64'sd1 <<< (SAMPLE_BITS-1)) - 64'sd1;
        if (v > hi)
            return hi[SAMPLE_BITS-1:0];
        else if (v < -hi - 64'sd1)
            return ~hi[SAMPLE_BITS-1:0];
        return v[SAMPLE_BITS-1:0];
    endfunction

    logic signed [63:0] px;
    assign px = 64'(x_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 5'd8;
            width_reg <= 16'd16384;
            outgn_reg <= 15'd8192;
            mono_reg  <= 1'b0;
            for (int i = 0; i < DEPTH; i++) coef_reg[i] <= '0;
            for (int i = 0; i < ALLPASS_STAGES; i++) apd_reg[i] <= '0;
            lpd_reg[0] <= '0; lpd_reg[1] <= '0;
            hpd_reg[0] <= '0; hpd_reg[1] <= '0;
            state_reg <= ST_IDLE;
            step_reg  <= S_AP_Y;
            stg_reg   <= '0;
            hp_reg    <= 1'b0;
            mval_reg  <= 1'b0;
            out_reg   <= '0;
            mcnt_reg  <= '0;
            mfirst_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_COUNT: count_reg <= cfg_data[4:0];
                    CFG_WIDTH: width_reg <= cfg_data;
                    CFG_OUTGN: outgn_reg <= cfg_data[14:0];
                    CFG_MONO:  mono_reg  <= cfg_data[0];
                    default: ;
                endcase
            end
            if (state_reg == ST_OUT && (!mval_reg || m_tready))
                mval_reg <= 1'b1;
            else if (m_tready)
                mval_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                    if (s_tvalid && s_tready)
                    begin
                        if (s_op)
                        begin
                            if (32'(s_idx) < 32'(DEPTH))
                                coef_reg[IDX_W'(s_idx)] <= s_cv;
                        end
                        else
                        begin
                            mid_reg  <= $signed({s_l[SAMPLE_BITS-1], s_l})
                                      + $signed({s_r[SAMPLE_BITS-1], s_r});
                            side_reg <= $signed({s_l[SAMPLE_BITS-1], s_l})
                                      - $signed({s_r[SAMPLE_BITS-1], s_r});
                            state_reg <= ST_PREP;
                        end
                    end
                ST_PREP:
                begin
                    x_reg   <= sat32(64'(mid_reg));
                    stg_reg <= '0;
                    hp_reg  <= 1'b0;
                    step_reg <= (n_eff == '0) ? S_LR_A0 : S_AP_Y;
                    state_reg <= ST_NEXT;
                end
                ST_NEXT:
                begin
                    // load the multiplier for the current step
                    acc_reg    <= '0;
                    mcand_reg  <= op_x;
                    mplier_reg <= op_c;
                    mfirst_reg <= 1'b1;
                    mcnt_reg   <= op_n;
                    shift_reg  <= op_sh;
                    state_reg  <= ST_MUL;
                end
                ST_MUL:
                begin
                    // one multiplier bit per cycle, msb first; the first bit has sign weight
                    if (mplier_reg[MP_W-1])
                    begin
                        if (mfirst_reg)
                            acc_reg <= (acc_reg <<< 1) - PROD_W'(mcand_reg);
                        else
                            acc_reg <= (acc_reg <<< 1) + PROD_W'(mcand_reg);
                    end
                    else
                        acc_reg <= acc_reg <<< 1;
                    mplier_reg <= mplier_reg << 1;
                    mfirst_reg <= 1'b0;
                    mcnt_reg   <= mcnt_reg - MCNT_W'(1);
                    if (mcnt_reg == MCNT_W'(1))
                        state_reg <= ST_EXEC;
                end
                ST_EXEC:
                begin
                    case (step_reg)
                        S_AP_Y:
                        begin
                            y_reg <= sat32(prod_r + 64'(apd_reg[stg_reg]));
                            step_reg <= S_AP_D;
                            state_reg <= ST_NEXT;
                        end
                        S_AP_D:
                        begin
                            apd_reg[stg_reg] <= sat32(px - prod_r);
                            x_reg <= y_reg;
                            if (STG_W'(stg_reg) + STG_W'(1) == n_eff)
                                step_reg <= S_LR_A0;
                            else
                                step_reg <= S_AP_Y;
                            stg_reg <= stg_reg + AP_W'(1);
                            state_reg <= ST_NEXT;
                        end
                        S_LR_A0:
                        begin
                            t_reg <= 40'(prod_r);
                            y_reg <= sat32(prod_r + 64'(hp_reg ? hpd_reg[0] : lpd_reg[0]));
                            step_reg <= S_LR_A1;
                            state_reg <= ST_NEXT;
                        end
                        S_LR_A1:
                        begin
                            u_reg <= 40'(hp_reg ? -prod_r : prod_r);
                            step_reg <= S_LR_B1;
                            state_reg <= ST_NEXT;
                        end
                        S_LR_B1:
                        begin
                            // delay 1 still holds its old value here
                            if (hp_reg)
                                hpd_reg[0] <= sat32(64'(u_reg) - prod_r + 64'(hpd_reg[1]));
                            else
                                lpd_reg[0] <= sat32(64'(u_reg) - prod_r + 64'(lpd_reg[1]));
                            step_reg <= S_LR_B2;
                            state_reg <= ST_NEXT;
                        end
                        S_LR_B2:
                        begin
                            if (hp_reg)
                            begin
                                hpd_reg[1] <= sat32(64'(t_reg) - prod_r);
                                step_reg <= S_WIDTH;
                            end
                            else
                            begin
                                lpd_reg[1] <= sat32(64'(t_reg) - prod_r);
                                x_reg  <= y_reg;
                                hp_reg <= 1'b1;
                                step_reg <= S_LR_A0;
                            end
                            state_reg <= ST_NEXT;
                        end
                        S_WIDTH:
                        begin
                            sl_reg <= SL_W'(64'(mid_reg) + 64'(side_reg) + prod_r);
                            sr_reg <= SL_W'(64'(mid_reg) - 64'(side_reg) - prod_r);
                            step_reg <= S_GL;
                            state_reg <= ST_NEXT;
                        end
                        S_GL:
                        begin
                            ol_reg <= sat_out(prod_r);
                            if (mono_reg)
                            begin
                                or_reg <= sat_out(prod_r);
                                state_reg <= ST_OUT;
                            end
                            else
                            begin
                                step_reg <= S_GR;
                                state_reg <= ST_NEXT;
                            end
                        end
                        S_GR:
                        begin
                            or_reg <= sat_out(prod_r);
                            state_reg <= ST_OUT;
                        end
                        default: state_reg <= ST_IDLE;
                    endcase
                end
                ST_OUT:
                    // wait here only while an earlier beat is still held
                    if (!mval_reg || m_tready)
                    begin
                        out_reg   <= {or_reg, ol_reg};
                        state_reg <= ST_POST;
                    end
                ST_POST:
                    state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // unused input bits above the packed fields
    logic unused_bits;
    assign unused_bits = ^s_tdata[IN_W-1:2*SAMPLE_BITS+5+COEF_BITS] ^ (^s_tdata);

endmodule
